// ----- src/mlp_inference_engine_assert.svh -----
// Assertion macros for the inference engine. Synthesis sees empty bodies.
`ifndef MLP_INFERENCE_ENGINE_ASSERT_SVH
`define MLP_INFERENCE_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define MLP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mlp_inference_engine: same-cycle check failed");
`define MLP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mlp_inference_engine: next-cycle check failed");
`else
`define MLP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MLP_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- src/mlp_pkg.sv -----
package mlp_pkg;

    localparam int DATA_W     = 16;
    localparam int IDX_W      = 6;
    localparam int LAYER_W    = 2;
    localparam int CFG_W      = 7;
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_LAYERS = 4;

    // Request codes on the input channel.
    localparam logic [1:0] REQ_WEIGHT = 2'd0;
    localparam logic [1:0] REQ_BIAS   = 2'd1;
    localparam logic [1:0] REQ_SAMPLE = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_LAYER_COUNT = 3'd0;
    localparam logic [2:0] CFG_WIDTH_IN    = 3'd1;
    localparam logic [2:0] CFG_WIDTH_L4    = 3'd5;
    localparam logic [2:0] CFG_ACT_MODES   = 3'd6;

    // Activation codes.
    localparam logic [1:0] ACT_RELU    = 2'd1;
    localparam logic [1:0] ACT_SIGMOID = 2'd2;

    typedef enum logic [1:0] {
        KIND_WEIGHT = 2'd0,
        KIND_BIAS   = 2'd1,
        KIND_SAMPLE = 2'd2
    } mlp_kind_t;

    // One queued transaction from the front to the back.
    typedef struct packed {
        mlp_kind_t                  kind;
        logic [LAYER_W-1:0]         layer;
        logic [IDX_W-1:0]           row;
        logic [IDX_W-1:0]           col;
        logic signed [DATA_W-1:0]   data;
        logic                       last;
    } mlp_item_t;

    // Configuration as seen by the compute engine.
    typedef struct packed {
        logic [2:0]             layer_count;
        logic [4:0][CFG_W-1:0]  widths;
        logic [7:0]             act_modes;
    } mlp_cfg_t;

    // Width register to count minus one, with out-of-range values clamped.
    function automatic logic [IDX_W-1:0] clamp_m1(input logic [CFG_W-1:0] w);
        if (w == '0) begin
            return '0;
        end else if (w > CFG_W'(MAX_WIDTH)) begin
            return IDX_W'(MAX_WIDTH - 1);
        end else begin
            return IDX_W'(w - CFG_W'(1));
        end
    endfunction

    // Layer count register to count minus one, clamped to 1..4.
    function automatic logic [LAYER_W-1:0] layers_m1(input logic [2:0] lc);
        if (lc <= 3'd1) begin
            return '0;
        end else if (lc >= 3'(MAX_LAYERS)) begin
            return LAYER_W'(MAX_LAYERS - 1);
        end else begin
            return LAYER_W'(lc - 3'd1);
        end
    endfunction

    // Saturating 32-bit accumulate.
    function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        return s[31:0];
    endfunction

    // Round Q15.16 to Q7.8 (add half, floor) and saturate to 16 bits.
    function automatic logic signed [DATA_W-1:0] to_q8(input logic signed [31:0] acc);
        logic signed [32:0] q;
        logic signed [24:0] r;
        q = {acc[31], acc} + 33'sd128;
        r = q[32:8];
        if (r > 25'sd32767) begin
            return 16'sh7fff;
        end else if (r < -25'sd32768) begin
            return 16'sh8000;
        end
        return r[15:0];
    endfunction

    // Upper half of the sigmoid table: 256 * sigmoid(j / 16), rounded.
    function automatic logic [8:0] sig_upper(input logic [7:0] j);
        logic [8:0] t;
        unique case (j)
            8'd0:  t = 9'd128;
            8'd1:  t = 9'd132;
            8'd2:  t = 9'd136;
            8'd3:  t = 9'd140;
            8'd4:  t = 9'd144;
            8'd5:  t = 9'd148;
            8'd6:  t = 9'd152;
            8'd7:  t = 9'd156;
            8'd8:  t = 9'd159;
            8'd9:  t = 9'd163;
            8'd10: t = 9'd167;
            8'd11: t = 9'd170;
            8'd12: t = 9'd174;
            8'd13: t = 9'd177;
            8'd14: t = 9'd181;
            8'd15: t = 9'd184;
            8'd16: t = 9'd187;
            8'd17: t = 9'd190;
            8'd18: t = 9'd193;
            8'd19: t = 9'd196;
            8'd20: t = 9'd199;
            8'd21: t = 9'd202;
            8'd22: t = 9'd204;
            8'd23: t = 9'd207;
            8'd24: t = 9'd209;
            8'd25: t = 9'd212;
            8'd26: t = 9'd214;
            8'd27: t = 9'd216;
            8'd28: t = 9'd218;
            8'd29: t = 9'd220;
            8'd30: t = 9'd222;
            8'd31: t = 9'd224;
            8'd32: t = 9'd225;
            8'd33: t = 9'd227;
            8'd34: t = 9'd229;
            8'd35: t = 9'd230;
            8'd36: t = 9'd232;
            8'd37: t = 9'd233;
            8'd38: t = 9'd234;
            8'd39: t = 9'd235;
            8'd40: t = 9'd237;
            8'd41: t = 9'd238;
            8'd42: t = 9'd239;
            8'd43: t = 9'd240;
            8'd44, 8'd45: t = 9'd241;
            8'd46: t = 9'd242;
            8'd47: t = 9'd243;
            8'd48: t = 9'd244;
            8'd49, 8'd50: t = 9'd245;
            8'd51, 8'd52: t = 9'd246;
            8'd53: t = 9'd247;
            8'd54, 8'd55, 8'd56: t = 9'd248;
            8'd57, 8'd58: t = 9'd249;
            8'd59, 8'd60, 8'd61: t = 9'd250;
            8'd62, 8'd63, 8'd64: t = 9'd251;
            8'd65, 8'd66, 8'd67, 8'd68: t = 9'd252;
            8'd69, 8'd70, 8'd71, 8'd72, 8'd73: t = 9'd253;
            8'd74, 8'd75, 8'd76, 8'd77, 8'd78,
            8'd79, 8'd80, 8'd81, 8'd82: t = 9'd254;
            8'd83, 8'd84, 8'd85, 8'd86, 8'd87, 8'd88,
            8'd89, 8'd90, 8'd91, 8'd92, 8'd93, 8'd94,
            8'd95, 8'd96, 8'd97, 8'd98, 8'd99: t = 9'd255;
            default: t = 9'd256;
        endcase
        return t;
    endfunction

    // Apply the activation selected by mode to a Q7.8 value.
    function automatic logic signed [DATA_W-1:0] activate(input logic signed [DATA_W-1:0] v,
                                                          input logic [1:0] mode);
        logic [15:0] t;
        logic [7:0]  idx;
        logic [8:0]  s;
        t   = 16'(v + 16'sd2048);
        idx = t[11:4];
        if (idx[7]) begin
            s = sig_upper({1'b0, idx[6:0]});
        end else begin
            s = 9'd256 - sig_upper(8'd128 - idx);
        end
        if (mode == ACT_RELU) begin
            return v[DATA_W-1] ? '0 : v;
        end else if (mode == ACT_SIGMOID) begin
            if (v < -16'sd2048) begin
                return '0;
            end else if (v >= 16'sd2048) begin
                return 16'sd256;
            end
            return {7'd0, s};
        end
        return v;
    endfunction

endpackage

// ----- src/mlp_front.sv -----
module mlp_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_req_type,
    input  logic [mlp_pkg::LAYER_W-1:0]         s_layer_sel,
    input  logic [mlp_pkg::IDX_W-1:0]           s_row_index,
    input  logic [mlp_pkg::IDX_W-1:0]           s_col_index,
    input  logic signed [mlp_pkg::DATA_W-1:0]   s_data_value,
    input  logic                                s_last_sample,
    output logic                                q_valid,
    input  logic                                q_ready,
    output mlp_pkg::mlp_item_t                  q_item
);
    import mlp_pkg::*;

    mlp_item_t  fifo_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;
    mlp_item_t  item_in;
    logic       item_ok;

    // Classify the incoming transaction; unknown request codes are dropped.
    always_comb begin
        item_ok       = 1'b1;
        item_in.kind  = KIND_WEIGHT;
        unique case (s_req_type)
            REQ_WEIGHT: item_in.kind = KIND_WEIGHT;
            REQ_BIAS:   item_in.kind = KIND_BIAS;
            REQ_SAMPLE: item_in.kind = KIND_SAMPLE;
            default:    item_ok      = 1'b0;
        endcase
        item_in.layer = s_layer_sel;
        item_in.row   = s_row_index;
        item_in.col   = s_col_index;
        item_in.data  = s_data_value;
        item_in.last  = s_last_sample;
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready && item_ok;
    assign q_valid = (count_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_item  = fifo_reg[rd_ptr_reg];

    // Two-entry queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= item_in;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ----- src/mlp_back.sv -----
module mlp_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mlp_pkg::mlp_cfg_t                   cfg,
    input  logic                                q_valid,
    output logic                                q_ready,
    input  mlp_pkg::mlp_item_t                  q_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [mlp_pkg::IDX_W-1:0]           m_out_index,
    output logic signed [mlp_pkg::DATA_W-1:0]   m_out_value,
    output logic                                m_last_result,
    output logic [mlp_pkg::IDX_W-1:0]           m_best_index
);
    import mlp_pkg::*;

    localparam int WADDR_W = LAYER_W + 2 * IDX_W;
    localparam int BADDR_W = LAYER_W + IDX_W;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_BIAS  = 9'b000000010,
        ST_LOADB = 9'b000000100,
        ST_MAC   = 9'b000001000,
        ST_DRAIN = 9'b000010000,
        ST_WRITE = 9'b000100000,
        ST_ORD   = 9'b001000000,
        ST_OLOAD = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    // Storage.
    logic signed [DATA_W-1:0] weight_mem [2**WADDR_W];
    logic signed [DATA_W-1:0] bias_mem   [2**BADDR_W];
    logic signed [DATA_W-1:0] act_a_mem  [MAX_WIDTH];
    logic signed [DATA_W-1:0] act_b_mem  [MAX_WIDTH];

    state_t                   state_reg, state_next;
    logic [LAYER_W-1:0]       l_reg;
    logic [IDX_W-1:0]         o_reg;
    logic [IDX_W-1:0]         i_reg;
    logic [IDX_W-1:0]         nin_m1_reg;
    logic                     src_b_reg;
    logic signed [31:0]       acc_reg;
    logic signed [DATA_W-1:0] q8_reg;
    logic                     v1_reg;
    logic                     v2_reg;
    logic signed [DATA_W-1:0] w_q_reg;
    logic signed [DATA_W-1:0] ra_q_reg;
    logic signed [DATA_W-1:0] rb_q_reg;
    logic signed [DATA_W-1:0] bias_q_reg;
    logic signed [31:0]       prod_reg;
    logic                     m_valid_reg;
    logic [IDX_W-1:0]         out_index_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    logic                     out_last_reg;
    logic [IDX_W-1:0]         out_best_reg;
    logic signed [DATA_W-1:0] best_val_reg;
    logic [IDX_W-1:0]         best_idx_reg;

    logic                     pop;
    logic                     start;
    logic [IDX_W-1:0]         nout_m1;
    logic [LAYER_W-1:0]       lay_m1;
    logic [1:0]               mode;
    logic signed [DATA_W-1:0] act_val;
    logic signed [DATA_W-1:0] act_rd;
    logic [IDX_W-1:0]         act_raddr;
    logic                     a_we;
    logic [IDX_W-1:0]         a_waddr;
    logic signed [DATA_W-1:0] a_wdata;
    logic                     b_we;
    logic                     out_last;
    logic                     take_best;
    logic [IDX_W-1:0]         cand_idx;

    // Per-layer settings and common selects.
    assign nout_m1   = clamp_m1(cfg.widths[3'({1'b0, l_reg}) + 3'd1]);
    assign lay_m1    = layers_m1(cfg.layer_count);
    assign mode      = cfg.act_modes[{l_reg, 1'b0} +: 2];
    assign q_ready   = (state_reg == ST_IDLE);
    assign pop       = q_valid && q_ready;
    assign start     = pop && (q_item.kind == KIND_SAMPLE) && q_item.last;
    assign act_val   = activate(q8_reg, mode);
    assign act_rd    = src_b_reg ? rb_q_reg : ra_q_reg;
    assign act_raddr = (state_reg == ST_ORD) ? o_reg : i_reg;

    // Activation buffer write ports: samples go to buffer A, layer outputs
    // go to whichever buffer is not the current source.
    assign a_we    = (pop && (q_item.kind == KIND_SAMPLE)) ||
                     ((state_reg == ST_WRITE) && src_b_reg);
    assign a_waddr = (state_reg == ST_WRITE) ? o_reg : q_item.col;
    assign a_wdata = (state_reg == ST_WRITE) ? act_val : q_item.data;
    assign b_we    = (state_reg == ST_WRITE) && !src_b_reg;

    // Weight store.
    always_ff @(posedge aclk) begin
        if (pop && (q_item.kind == KIND_WEIGHT)) begin
            weight_mem[{q_item.layer, q_item.row, q_item.col}] <= q_item.data;
        end
        w_q_reg <= weight_mem[{l_reg, o_reg, i_reg}];
    end

    // Bias store.
    always_ff @(posedge aclk) begin
        if (pop && (q_item.kind == KIND_BIAS)) begin
            bias_mem[{q_item.layer, q_item.row}] <= q_item.data;
        end
        bias_q_reg <= bias_mem[{l_reg, o_reg}];
    end

    // Activation buffer A.
    always_ff @(posedge aclk) begin
        if (a_we) begin
            act_a_mem[a_waddr] <= a_wdata;
        end
        ra_q_reg <= act_a_mem[act_raddr];
    end

    // Activation buffer B.
    always_ff @(posedge aclk) begin
        if (b_we) begin
            act_b_mem[o_reg] <= act_val;
        end
        rb_q_reg <= act_b_mem[act_raddr];
    end

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (start) state_next = ST_BIAS;
            ST_BIAS:  state_next = ST_LOADB;
            ST_LOADB: state_next = ST_MAC;
            ST_MAC:   if (i_reg == nin_m1_reg) state_next = ST_DRAIN;
            ST_DRAIN: if (!v1_reg && !v2_reg) state_next = ST_WRITE;
            ST_WRITE: begin
                if ((o_reg == nout_m1) && (l_reg == lay_m1)) begin
                    state_next = ST_ORD;
                end else begin
                    state_next = ST_BIAS;
                end
            end
            ST_ORD:   state_next = ST_OLOAD;
            ST_OLOAD: state_next = ST_OUT;
            ST_OUT: begin
                if (m_ready) begin
                    state_next = (o_reg == nin_m1_reg) ? ST_IDLE : ST_ORD;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Multiply-accumulate pipeline: read, multiply, accumulate.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= (state_reg == ST_MAC);
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= 32'(w_q_reg * act_rd);
        if (state_reg == ST_LOADB) begin
            acc_reg <= 32'(bias_q_reg) <<< 8;
        end else if (v2_reg) begin
            acc_reg <= sat_add32(acc_reg, prod_reg);
        end
        if (state_reg == ST_DRAIN) begin
            q8_reg <= to_q8(acc_reg);
        end
    end

    // Running maximum over emitted results.
    assign out_last  = (o_reg == nin_m1_reg);
    assign take_best = (o_reg == '0) || (act_rd > best_val_reg);
    assign cand_idx  = take_best ? o_reg : best_idx_reg;

    // Sequencer registers and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            l_reg       <= '0;
            o_reg       <= '0;
            i_reg       <= '0;
            nin_m1_reg  <= '0;
            src_b_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        l_reg      <= '0;
                        o_reg      <= '0;
                        nin_m1_reg <= clamp_m1(cfg.widths[0]);
                        src_b_reg  <= 1'b0;
                    end
                end
                ST_LOADB: i_reg <= '0;
                ST_MAC:   i_reg <= i_reg + IDX_W'(1);
                ST_WRITE: begin
                    if (o_reg == nout_m1) begin
                        o_reg      <= '0;
                        nin_m1_reg <= nout_m1;
                        src_b_reg  <= ~src_b_reg;
                        if (l_reg != lay_m1) begin
                            l_reg <= l_reg + LAYER_W'(1);
                        end
                    end else begin
                        o_reg <= o_reg + IDX_W'(1);
                    end
                end
                ST_OLOAD: m_valid_reg <= 1'b1;
                ST_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        o_reg       <= o_reg + IDX_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Result payload, loaded once per result.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_OLOAD) begin
            out_index_reg <= o_reg;
            out_value_reg <= act_rd;
            out_last_reg  <= out_last;
            out_best_reg  <= out_last ? cand_idx : '0;
            if (take_best) begin
                best_val_reg <= act_rd;
            end
            best_idx_reg  <= cand_idx;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_index   = out_index_reg;
    assign m_out_value   = out_value_reg;
    assign m_last_result = out_last_reg;
    assign m_best_index  = out_best_reg;

endmodule

// ----- src/mlp_inference_engine.sv -----
// Channel   Handshake          Payload
// s_        s_valid/s_ready    req_type, layer_sel, row_index, col_index, data_value,
//                              last_sample
// m_        m_valid/m_ready    out_index, out_value, last_result, best_index
// cfg_      cfg_we             cfg_index, cfg_data (no wait, no read-back)
//
// Weight, bias and sample transactions are taken one per cycle while the two-entry
// queue has room, and the back end takes them from it only while idle.
// A final sample starts inference: each neuron goes through bias read and load,
// products, drain and write-back on the single multiply-accumulate unit. Output can
// stall. The queue keeps accepting until it is full while the back end works.
// Reset is synchronous, active low; stores hold no reset value.
`include "mlp_inference_engine_assert.svh"

module mlp_inference_engine (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_req_type,
    input  logic [mlp_pkg::LAYER_W-1:0]         s_layer_sel,
    input  logic [mlp_pkg::IDX_W-1:0]           s_row_index,
    input  logic [mlp_pkg::IDX_W-1:0]           s_col_index,
    input  logic signed [mlp_pkg::DATA_W-1:0]   s_data_value,
    input  logic                                s_last_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [mlp_pkg::IDX_W-1:0]           m_out_index,
    output logic signed [mlp_pkg::DATA_W-1:0]   m_out_value,
    output logic                                m_last_result,
    output logic [mlp_pkg::IDX_W-1:0]           m_best_index,
    input  logic                                cfg_we,
    input  logic [2:0]                          cfg_index,
    input  logic [7:0]                          cfg_data
);
    import mlp_pkg::*;

    logic [2:0]             layer_count_reg;
    logic [4:0][CFG_W-1:0]  widths_reg;
    logic [7:0]             act_modes_reg;
    mlp_cfg_t               cfg;
    logic                   q_valid;
    logic                   q_ready;
    mlp_item_t              q_item;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layer_count_reg <= 3'd1;
            widths_reg      <= {5{CFG_W'(1)}};
            act_modes_reg   <= '0;
        end else if (cfg_we) begin
            if (cfg_index == CFG_LAYER_COUNT) begin
                layer_count_reg <= cfg_data[2:0];
            end else if ((cfg_index >= CFG_WIDTH_IN) && (cfg_index <= CFG_WIDTH_L4)) begin
                widths_reg[cfg_index - CFG_WIDTH_IN] <= cfg_data[CFG_W-1:0];
            end else if (cfg_index == CFG_ACT_MODES) begin
                act_modes_reg <= cfg_data;
            end
        end
    end

    assign cfg.layer_count = layer_count_reg;
    assign cfg.widths      = widths_reg;
    assign cfg.act_modes   = act_modes_reg;

    // Front end: accepts and classifies transactions.
    mlp_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_layer_sel   (s_layer_sel),
        .s_row_index   (s_row_index),
        .s_col_index   (s_col_index),
        .s_data_value  (s_data_value),
        .s_last_sample (s_last_sample),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item)
    );

    // Back end: stores, multiply-accumulate sequencer and result register.
    mlp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_index   (m_out_index),
        .m_out_value   (m_out_value),
        .m_last_result (m_last_result),
        .m_best_index  (m_best_index)
    );

    // Only the final result carries a best index.
    `MLP_ASSERT_IMP(a_best_only_last, aclk, aresetn, m_valid && !m_last_result, m_best_index == '0)
    // The back end takes no queued transaction while a result is pending.
    `MLP_ASSERT_IMP(a_no_pop_on_result, aclk, aresetn, m_valid, !q_ready)
    // A final sample sends the back end into compute.
    `MLP_ASSERT_NXT(a_busy_after_start, aclk, aresetn, q_valid && q_ready && (q_item.kind == KIND_SAMPLE) && q_item.last, !q_ready)

endmodule
